// ===== sv/bba_pkg.sv =====
package bba_pkg;

	// Bitmap geometry
	localparam int MAX_BLOCKS    = 4096;
	localparam int MAP_WORD_BITS = 32;
	localparam int MAP_WORDS     = MAX_BLOCKS / MAP_WORD_BITS;
	localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
	localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
	localparam int BLK_W         = WORD_IDX_W + BIT_IDX_W;
	localparam int TOTAL_W       = BLK_W + 1;

	typedef logic [BLK_W-1:0]         blk_t;
	typedef logic [TOTAL_W-1:0]       total_t;
	typedef logic [MAP_WORD_BITS-1:0] map_word_t;
	typedef logic [1:0]               status_t;

	localparam total_t TOTAL_RESET = total_t'(MAX_BLOCKS);

	// Commands
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result status codes
	localparam status_t ST_OK           = 2'd0;
	localparam status_t ST_NO_BLOCKS    = 2'd1;
	localparam status_t ST_ALREADY_FREE = 2'd2;
	localparam status_t ST_OUT_OF_RANGE = 2'd3;

endpackage

// ===== sv/bitmap_block_allocator_core.sv =====
// First-fit block allocator over an in-use bitmap of 4096 blocks (128 words of 32 bits).
// Input channel (in_valid / in_stall): command 0 allocates the lowest free block below
// total_blocks, command 1 frees block_number. One item is worked at a time; in_stall is
// high while an item is in flight.
// Output channel (out_valid / out_stall): one transfer per item with block_number_res and
// status (0 ok, 1 out of blocks, 2 block already free, 3 out of range). The result sits in
// an output register, so the next item is taken while a result still waits.
// Flow: a free reads its map word on the transfer, then checks and writes the word back,
// then loads the result; an allocate reads one map word per cycle from word 0, pipelined
// against the registered RAM read, checks each word as it returns, writes back the word that
// holds the granted block and loads the result; with total_blocks of 0 an allocate goes
// straight to the result load. The next item is taken once the result of the last one has
// moved into the output register, so the scan through the map RAM sets the pace.
// Configuration: cfg_wr_en writes total_blocks (13 bits, values above 4096 act as 4096);
// write it only while no item is in flight.
// Reset: arst_n clears the per-word valid bits, so every block reads free at once with no
// clearing pass; total_blocks returns to 4096. A stalled output holds its result and the
// block holds the next finished result inside until the output register frees up.
module bitmap_block_allocator_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  bba_pkg::total_t      cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  bba_pkg::blk_t        block_number,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bba_pkg::blk_t        block_number_res,
	output bba_pkg::status_t     status
);
	import bba_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FCHK = 2'd2;
	localparam logic [1:0] S_PUSH = 2'd3;

	logic [1:0] state_q;
	total_t     total_q;

	// Latched request for a free
	blk_t blk_q;

	// Scan issue counter: one wider than a word index so it can stop past the last word
	logic [WORD_IDX_W:0] issue_cnt_q;

	// Read stage
	logic                  chk_valid_s1;
	logic [WORD_IDX_W-1:0] chk_word_s1;
	logic                  vld_s1;

	// Per-word valid bits: a word never written reads as all free
	logic [MAP_WORDS-1:0] map_vld_q;

	// Pending result and output register
	blk_t    res_blk_q;
	status_t res_st_q;
	logic    out_valid_q;
	blk_t    out_blk_q;
	status_t out_st_q;

	// RAM ports
	logic                  rd_en;
	logic [WORD_IDX_W-1:0] rd_addr;
	map_word_t             rd_data;
	logic                  wr_en;
	logic [WORD_IDX_W-1:0] wr_addr;
	map_word_t             wr_data;

	// Scan and check logic
	total_t                limit;
	total_t                limit_m1;
	logic [WORD_IDX_W-1:0] last_word;
	map_word_t             rd_word;
	map_word_t             in_range;
	map_word_t             free_bits;
	logic                  found_any;
	logic [BIT_IDX_W-1:0]  found_idx;
	logic                  word_full_range;
	logic                  word_edge;
	logic                  scan_issue;
	logic                  scan_found;
	logic                  scan_last;
	logic                  in_xfer;
	logic                  out_free;
	logic                  blk_in_range;
	logic [BIT_IDX_W-1:0]  blk_bit;

	bba_ram #(
		.WIDTH(MAP_WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Saturate the configured total to the map size
	assign limit     = (total_q > total_t'(MAX_BLOCKS)) ? total_t'(MAX_BLOCKS) : total_q;
	assign limit_m1  = limit - total_t'(1);
	assign last_word = limit_m1[BLK_W-1:BIT_IDX_W];

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign rd_word = vld_s1 ? rd_data : '0;

	// Bits of the word under check that lie below the total
	assign word_full_range = {1'b0, chk_word_s1} < limit[TOTAL_W-1:BIT_IDX_W];
	assign word_edge       = {1'b0, chk_word_s1} == limit[TOTAL_W-1:BIT_IDX_W];

	always_comb begin
		for (int i = 0; i < MAP_WORD_BITS; i++) begin
			in_range[i] = word_full_range ||
				(word_edge && (BIT_IDX_W'(i) < limit[BIT_IDX_W-1:0]));
		end
	end

	assign free_bits = ~rd_word & in_range;

	// Lowest free bit
	always_comb begin
		found_any = 1'b0;
		found_idx = '0;
		for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				found_any = 1'b1;
				found_idx = BIT_IDX_W'(i);
			end
		end
	end

	assign scan_issue = (state_q == S_SCAN) && (issue_cnt_q < (WORD_IDX_W + 1)'(MAP_WORDS));
	assign scan_found = (state_q == S_SCAN) && chk_valid_s1 && found_any;
	assign scan_last  = (state_q == S_SCAN) && chk_valid_s1 && !found_any &&
		(chk_word_s1 == last_word);

	assign blk_in_range = {1'b0, blk_q} < limit;
	assign blk_bit      = blk_q[BIT_IDX_W-1:0];

	// Map read: free reads its word on transfer, allocate streams words during the scan
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = issue_cnt_q[WORD_IDX_W-1:0];
		if (in_xfer && (command == CMD_FREE)) begin
			rd_en   = 1'b1;
			rd_addr = block_number[BLK_W-1:BIT_IDX_W];
		end else if (scan_issue) begin
			rd_en = 1'b1;
		end
	end

	// Map write-back: set the granted bit, or clear the freed one
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = chk_word_s1;
		wr_data = rd_word | (map_word_t'(1) << found_idx);
		if (scan_found) begin
			wr_en = 1'b1;
		end else if ((state_q == S_FCHK) && blk_in_range && rd_word[blk_bit]) begin
			wr_en   = 1'b1;
			wr_addr = blk_q[BLK_W-1:BIT_IDX_W];
			wr_data = rd_word & ~(map_word_t'(1) << blk_bit);
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			blk_q <= block_number;
		end
		if (rd_en) begin
			chk_word_s1 <= rd_addr;
			vld_s1      <= map_vld_q[rd_addr];
		end
		if ((state_q == S_PUSH) && out_free) begin
			out_blk_q <= res_blk_q;
			out_st_q  <= res_st_q;
		end
		// Hold the result of the item just finished
		if (in_xfer && (command == CMD_ALLOC) && (limit == '0)) begin
			res_blk_q <= '0;
			res_st_q  <= ST_NO_BLOCKS;
		end else if (scan_found) begin
			res_blk_q <= {chk_word_s1, found_idx};
			res_st_q  <= ST_OK;
		end else if (scan_last) begin
			res_blk_q <= '0;
			res_st_q  <= ST_NO_BLOCKS;
		end else if (state_q == S_FCHK) begin
			res_blk_q <= blk_q;
			priority if (!blk_in_range) begin
				res_st_q <= ST_OUT_OF_RANGE;
			end else if (!rd_word[blk_bit]) begin
				res_st_q <= ST_ALREADY_FREE;
			end else begin
				res_st_q <= ST_OK;
			end
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			total_q      <= TOTAL_RESET;
			issue_cnt_q  <= '0;
			chk_valid_s1 <= 1'b0;
			map_vld_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
			end
			if (wr_en) begin
				map_vld_q[wr_addr] <= 1'b1;
			end
			// Drop reads still in flight once the scan ends
			chk_valid_s1 <= scan_issue && !scan_found && !scan_last;
			if (scan_issue) begin
				issue_cnt_q <= issue_cnt_q + (WORD_IDX_W + 1)'(1);
			end
			if ((state_q == S_PUSH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					issue_cnt_q <= '0;
					if (in_xfer) begin
						if (command == CMD_FREE) begin
							state_q <= S_FCHK;
						end else if (limit == '0) begin
							state_q <= S_PUSH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_found || scan_last) begin
						state_q <= S_PUSH;
					end
				end
				S_FCHK: begin
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign block_number_res = out_blk_q;
	assign status           = out_st_q;

	// A transfer always starts work on the item
	a_xfer_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != S_IDLE))
		else $error("accepted item did not leave idle");

	// The map is written back only while checking a scan or a free
	a_write_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == S_SCAN) || (state_q == S_FCHK)))
		else $error("map write outside a check state");

	// Scan reads in flight never outlive the scan
	a_chk_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_valid_s1 |-> (state_q == S_SCAN))
		else $error("scan read pending outside the scan");

	// An out-of-blocks result always carries block zero
	a_no_blocks_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_st_q == ST_NO_BLOCKS)) |-> (out_blk_q == '0))
		else $error("out-of-blocks result with nonzero block");

endmodule

// ===== sv/bba_ram.sv =====
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== verif/tb_bitmap_block_allocator_core.sv =====
`timescale 1ns / 100ps

module tb_bitmap_block_allocator_core;
	import bba_pkg::*;

	// One request as offered on the input channel
	typedef struct packed {
		logic cmd;
		blk_t blk;
	} alloc_req_t;

	// One answer as seen on the output channel
	typedef struct packed {
		blk_t    blk;
		status_t st;
	} alloc_res_t;

	localparam int IDLE_LIMIT   = 4000;  // cycles with no transfer on either side
	localparam int LONG_HOLD    = 400;   // receiver hold-off used to back up the block
	localparam int SETTLE_TIME  = 200;   // covers the longest scan through all 128 map words, with margin
	localparam int PHASE_ITEMS  = 150;
	localparam int PHASES       = 13;
	localparam int REPORT_LIMIT = 10;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    cfg_wr_en    = 1'b0;
	total_t  cfg_wr_data  = '0;
	logic    in_valid     = 1'b0;
	logic    in_stall;
	logic    command      = CMD_ALLOC;
	blk_t    block_number = '0;
	logic    out_valid;
	logic    out_stall    = 1'b0;
	blk_t    block_number_res;
	status_t status;

	bitmap_block_allocator_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.block_number     (block_number),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.block_number_res (block_number_res),
		.status           (status)
	);

	// Shadow copy of the allocator: one in-use bit per block plus the total register
	bit [MAX_BLOCKS-1:0] map_shadow;
	total_t              total_shadow;
	int unsigned         grant_span;     // one past the highest block ever granted

	alloc_req_t  pending_reqs[$];        // requests waiting for the driver
	alloc_res_t  expected_res[$];        // answers owed by the block, oldest first

	int unsigned fail_count;
	int unsigned in_xfers;
	int unsigned out_xfers;
	int unsigned hold_asks;              // bumped by the sequencer to ask for a long hold

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Work out the answer to one accepted request and advance the shadow map.
	// First fit scans upward from block 0, stopping below the saturated total;
	// a free checks range before checking the bit.
	function automatic alloc_res_t allocate_or_release(alloc_req_t req);
		alloc_res_t  res;
		int unsigned lim;
		bit          found;
		lim   = (total_shadow > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_shadow);
		found = 1'b0;
		if (req.cmd == CMD_ALLOC) begin
			res.blk = '0;
			res.st  = ST_NO_BLOCKS;
			for (int b = 0; b < lim && !found; b++) begin
				if (!map_shadow[b]) begin
					map_shadow[b] = 1'b1;
					res.blk       = blk_t'(b);
					res.st        = ST_OK;
					found         = 1'b1;
					if (b + 1 > grant_span)
						grant_span = b + 1;
				end
			end
		end else begin
			// echo the block whatever the outcome
			res.blk = req.blk;
			if (int'(req.blk) >= lim)
				res.st = ST_OUT_OF_RANGE;
			else if (!map_shadow[req.blk])
				res.st = ST_ALREADY_FREE;
			else begin
				map_shadow[req.blk] = 1'b0;
				res.st              = ST_OK;
			end
		end
		return res;
	endfunction

	function automatic void log_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents queued requests in bursts of random length with
	// random gaps. Hold the payload while stalled; predict on each transfer.
	// ------------------------------------------------------------------
	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk) begin
		alloc_req_t req;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (in_valid && !in_stall) begin
				req.cmd = command;
				req.blk = block_number;
				expected_res.push_back(allocate_or_release(req));
				in_xfers++;
			end
			// only move on when nothing is held on the channel
			if (!in_valid || !in_stall) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 40);
					// a quarter of the bursts run straight into the next one
					gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
				end
				if (burst_left > 0 && pending_reqs.size() > 0) begin
					req = pending_reqs.pop_front();
					in_valid     <= 1'b1;
					command      <= req.cmd;
					block_number <= req.blk;
					burst_left--;
				end else begin
					// drop valid and scramble the idle payload
					in_valid     <= 1'b0;
					command      <= 1'($urandom);
					block_number <= blk_t'($urandom);
					if (burst_left == 0 && gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each output transfer against the oldest expectation
	// and drives out_stall from a changing pattern, with long holds on
	// request from the sequencer.
	// ------------------------------------------------------------------
	int unsigned hold_served;
	int unsigned hold_left;
	int unsigned pattern_cyc;
	int unsigned stall_mode;

	always @(posedge clk) begin
		alloc_res_t want;
		logic       stall_next;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_xfers++;
				if (expected_res.size() == 0) begin
					log_failure($sformatf("unexpected result: blk %0d status %0d",
						block_number_res, status));
				end else begin
					want = expected_res.pop_front();
					if (block_number_res !== want.blk || status !== want.st)
						log_failure($sformatf(
							"mismatch: blk exp %0d got %0d, status exp %0d got %0d",
							want.blk, block_number_res, want.st, status));
				end
			end
			// pick the stall for the next cycle
			pattern_cyc++;
			if (pattern_cyc % 256 == 0)
				stall_mode = $urandom_range(3);
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (hold_asks != hold_served) begin
				hold_served = hold_asks;
				hold_left   = LONG_HOLD;
				stall_next  = 1'b1;
			end else begin
				case (stall_mode)
					0: stall_next = 1'b0;
					1: stall_next = ($urandom_range(3) == 0);
					2: stall_next = ($urandom_range(9) < 7);
					default: stall_next = (pattern_cyc % 5) < 2;
				endcase
			end
			out_stall <= stall_next;
		end
	end

	// Watchdog: end the run if neither channel moves for too long
	int unsigned idle_cycles;
	int unsigned last_xfers;

	always @(negedge clk) begin
		if (in_xfers + out_xfers != last_xfers) begin
			last_xfers  = in_xfers + out_xfers;
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer helpers
	// ------------------------------------------------------------------

	// Queue a request; keep the backlog short so free targets track the map.
	task automatic push_req(logic cmd, blk_t blk);
		alloc_req_t req;
		req.cmd = cmd;
		req.blk = blk;
		while (pending_reqs.size() >= 4)
			@(negedge clk);
		pending_reqs.push_back(req);
	endtask

	// Pause the sender until every owed answer has arrived.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_res.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_total(total_t value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		total_shadow = value;
		@(negedge clk);
	endtask

	// Random request. Frees mostly aim at the granted region, where first fit
	// keeps blocks packed; the rest hit any block number, including the top.
	task automatic push_random(int unsigned alloc_pct);
		logic cmd;
		blk_t blk;
		cmd = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
		case ($urandom_range(9))
			0, 1: blk = blk_t'($urandom);
			2: blk = blk_t'(MAX_BLOCKS - 1 - $urandom_range(3));
			default: blk = blk_t'($urandom_range(0, (grant_span == 0) ? 0 : grant_span - 1));
		endcase
		push_req(cmd, blk);
	endtask

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	total_t      phase_total[PHASES] = '{
		total_t'(4096), total_t'(40),   total_t'(100),  total_t'(1),
		total_t'(8191), total_t'(700),  total_t'(33),   total_t'(0),
		total_t'(4096), total_t'(64),   total_t'(2000), total_t'(4097),
		total_t'(4096)
	};
	int unsigned phase_alloc[PHASES] = '{75, 55, 50, 50, 80, 60, 50, 50, 70, 45, 55, 65, 40};

	initial begin
		map_shadow   = '0;
		total_shadow = TOTAL_RESET;
		grant_span   = 0;
		fail_count   = 0;
		in_xfers     = 0;
		out_xfers    = 0;
		hold_asks    = 0;
		hold_served  = 0;
		hold_left    = 0;
		pattern_cyc  = 0;
		stall_mode   = 0;
		idle_cycles  = 0;
		last_xfers   = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset total: grant the first blocks, free one twice, free the top
		// block while it is free, free block 0 twice
		push_req(CMD_ALLOC, '0);
		push_req(CMD_ALLOC, '1);
		push_req(CMD_ALLOC, '0);
		push_req(CMD_FREE,  blk_t'(1));
		push_req(CMD_FREE,  blk_t'(1));
		push_req(CMD_ALLOC, blk_t'(1));
		push_req(CMD_FREE,  blk_t'(MAX_BLOCKS - 1));
		push_req(CMD_FREE,  blk_t'(0));
		push_req(CMD_FREE,  blk_t'(0));
		push_req(CMD_ALLOC, '1);
		push_req(CMD_FREE,  blk_t'(12'hABC));
		wait_drained();

		// Zero total: nothing to grant, every free is out of range
		write_total('0);
		push_req(CMD_ALLOC, '0);
		push_req(CMD_FREE,  blk_t'(0));
		push_req(CMD_FREE,  blk_t'(MAX_BLOCKS - 1));
		wait_drained();

		// Oversized totals saturate at the map size
		write_total('1);
		push_req(CMD_FREE,  blk_t'(MAX_BLOCKS - 1));
		push_req(CMD_ALLOC, '0);
		wait_drained();
		write_total(total_t'(MAX_BLOCKS + 1));
		push_req(CMD_ALLOC, '0);
		wait_drained();

		// Single block: out of blocks while block 0 is held, range check first
		write_total(total_t'(1));
		push_req(CMD_ALLOC, '0);
		push_req(CMD_FREE,  blk_t'(0));
		push_req(CMD_ALLOC, '0);
		push_req(CMD_ALLOC, '0);
		push_req(CMD_FREE,  blk_t'(1));
		push_req(CMD_FREE,  blk_t'(MAX_BLOCKS - 1));
		wait_drained();

		// Random phases, each at its own total, drained before the next write
		for (int p = 0; p < PHASES; p++) begin
			write_total(phase_total[p]);
			// back the block up behind a long receiver hold twice in the run
			if (p == 1 || p == 8)
				hold_asks++;
			for (int i = 0; i < PHASE_ITEMS; i++)
				push_random(phase_alloc[p]);
			wait_drained();
		end

		repeat (SETTLE_TIME) @(negedge clk);
		if (fail_count == 0 && expected_res.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
